@@ sv/http_request_head_parser_core_macros.svh @@
// Assertion macros for the request head parser.
`ifndef HTTP_REQUEST_HEAD_PARSER_CORE_MACROS_SVH
`define HTTP_REQUEST_HEAD_PARSER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define HRHP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HRHP_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define HRHP_ASSERT(lbl, clk, rst, prop, msg)
`define HRHP_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

@@ sv/hrhp_pkg.sv @@
package hrhp_pkg;

  localparam int OFFSET_BITS     = 16;
  localparam int KEY_STORE_DEPTH = 32;
  localparam int TABLE_ENTRIES   = 17;
  localparam int KS_AW           = $clog2(KEY_STORE_DEPTH);
  localparam int LCC_BITS        = 16;
  localparam int NAME_MAX        = 19;

  localparam logic [4:0] UNKNOWN_IDX = 5'd17;
  localparam logic [4:0] LENGTH_IDX  = 5'd7;

  localparam logic [1:0] V_CONT     = 2'd0;
  localparam logic [1:0] V_PENDING  = 2'd1;
  localparam logic [1:0] V_COMPLETE = 2'd2;
  localparam logic [1:0] V_ERROR    = 2'd3;

  localparam logic [2:0] K_NONE     = 3'd0;
  localparam logic [2:0] K_METHOD   = 3'd1;
  localparam logic [2:0] K_URI      = 3'd2;
  localparam logic [2:0] K_QUERY    = 3'd3;
  localparam logic [2:0] K_PROTOCOL = 3'd4;
  localparam logic [2:0] K_KEY      = 3'd5;
  localparam logic [2:0] K_VALUE    = 3'd6;

  localparam logic [0:0] REG_METHOD_MAX = 1'd0;
  localparam logic [0:0] REG_PROTO_LEN  = 1'd1;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [4:0] NAME_LEN [TABLE_ENTRIES] = '{
    5'd6, 5'd14, 5'd15, 5'd15, 5'd13, 5'd6, 5'd10, 5'd14, 5'd13,
    5'd12, 5'd17, 5'd4, 5'd13, 5'd19, 5'd7, 5'd5, 5'd10
  };

  localparam logic [8*NAME_MAX-1:0] NAME_TEXT [TABLE_ENTRIES] = '{
    "Accept", "Accept-Charset", "Accept-Encoding", "Accept-Language",
    "Authorization", "Cookie", "Connection", "Content-Length", "Content-Range",
    "Content-Type", "If-Modified-Since", "Host", "Last-Modified",
    "Last-Modified-Since", "Referer", "Range", "User-Agent"
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
    logic       is_cr;
    logic       is_lf;
    logic       is_sp;
  } item_t;

  typedef struct packed {
    logic             en;
    logic [KS_AW-1:0] addr;
    logic [7:0]       data;
  } key_wr_t;

  typedef struct packed {
    logic                   start;
    logic [4:0]             lo;
    logic [4:0]             hi;
    logic [OFFSET_BITS-1:0] len;
  } match_req_t;

  // text is right-justified in the vector, char 0 is the leftmost
  function automatic logic [7:0] name_char(input logic [4:0] idx, input logic [4:0] pos);
    logic [8*NAME_MAX-1:0] t;
    logic [4:0]            sh;
    t  = NAME_TEXT[idx];
    sh = NAME_LEN[idx] - 5'd1 - pos;
    return t[{sh, 3'b000} +: 8];
  endfunction

endpackage

@@ sv/hrhp_front.sv @@
module hrhp_front
  import hrhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       chunk_end,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t      slot [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= '{data_byte: data_byte, chunk_end: chunk_end,
                      is_cr: (data_byte == CH_CR), is_lf: (data_byte == CH_LF),
                      is_sp: (data_byte == CH_SP)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

@@ sv/hrhp_keymatch.sv @@
module hrhp_keymatch
  import hrhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  key_wr_t    kw,
  input  match_req_t req,
  output logic       done,
  output logic [4:0] hidx
);

  typedef enum logic [2:0] {
    KM_IDLE = 3'b001,
    KM_CHK  = 3'b010,
    KM_CMP  = 3'b100
  } km_state_t;

  km_state_t              st;
  logic [7:0]             mem [KEY_STORE_DEPTH];
  logic [7:0]             rd_data;
  logic [4:0]             li, hi;
  logic [KS_AW-1:0]       k;
  logic [OFFSET_BITS-1:0] len;

  always_ff @(posedge clk) begin
    if (kw.en) mem[kw.addr] <= kw.data;
    rd_data <= mem[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= KM_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        KM_IDLE: begin
          if (req.start) begin
            li  <= req.lo;
            hi  <= req.hi;
            len <= req.len;
            k   <= KS_AW'(1);
            st  <= KM_CHK;
          end
        end
        KM_CHK: begin
          if (OFFSET_BITS'(NAME_LEN[li]) != len) begin
            if (li == hi) begin
              hidx <= UNKNOWN_IDX;
              done <= 1'b1;
              st   <= KM_IDLE;
            end else begin
              li <= li + 5'd1;
              k  <= KS_AW'(1);
            end
          end else if (OFFSET_BITS'(k) >= len) begin
            hidx <= li;
            done <= 1'b1;
            st   <= KM_IDLE;
          end else begin
            st <= KM_CMP;
          end
        end
        KM_CMP: begin
          if (rd_data != name_char(li, 5'(k))) begin
            if (li == hi) begin
              hidx <= UNKNOWN_IDX;
              done <= 1'b1;
              st   <= KM_IDLE;
            end else begin
              li <= li + 5'd1;
              k  <= KS_AW'(1);
              st <= KM_CHK;
            end
          end else begin
            k  <= k + KS_AW'(1);
            st <= KM_CHK;
          end
        end
        default: st <= KM_IDLE;
      endcase
    end
  end

endmodule

@@ sv/hrhp_back.sv @@
`include "http_request_head_parser_core_macros.svh"

module hrhp_back
  import hrhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  verdict,
  output logic [2:0]  field_kind,
  output logic [15:0] field_start,
  output logic [15:0] field_stop,
  output logic [4:0]  header_index,
  output logic [31:0] content_len
);

  localparam int OB = OFFSET_BITS;

  typedef enum logic [2:0] {
    BS_IDLE = 3'b001,
    BS_PASS = 3'b010,
    BS_LOOK = 3'b100
  } bstate_t;

  typedef enum logic [3:0] {
    LV_FIRST = 4'b0001,
    LV_HEAD  = 4'b0010,
    LV_END   = 4'b0100,
    LV_BODY  = 4'b1000
  } level_t;

  typedef enum logic [10:0] {
    PS_METHOD = 11'b00000000001,
    PS_URI    = 11'b00000000010,
    PS_QUERY  = 11'b00000000100,
    PS_PROT   = 11'b00000001000,
    PS_LF     = 11'b00000010000,
    PS_FCONT  = 11'b00000100000,
    PS_FFIN   = 11'b00001000000,
    PS_KEY    = 11'b00010000000,
    PS_VAL    = 11'b00100000000,
    PS_VALRUN = 11'b01000000000,
    PS_HEND   = 11'b10000000000
  } pstate_t;

  bstate_t bst;
  item_t   cur;
  level_t  lv, lv_next;
  pstate_t ps, ps_next;
  logic [LCC_BITS-1:0] lcc, lcc_next;
  logic [OB-1:0] boff, fb, fb_next, key_len, key_len_next;
  logic [4:0]  cand_lo, cand_lo_next, cand_hi, cand_hi_next;
  logic [31:0] vnum, vnum_next, hlv, bc, bc_next;
  logic        vneg, vneg_next;
  logic [1:0]  vphase, vphase_next;
  logic [7:0]  prev;
  logic [1:0]  fv;
  logic [4:0]  mml, pfl;

  logic [1:0]  v, vf;
  logic [2:0]  kind;
  logic [OB-1:0] fs, fe, pos, mlen;
  logic        mark, redo, look, sticky;
  logic [35:0] prod;
  logic [3:0]  dval;
  logic        is_digit, is_ws;
  logic [7:0]  b;
  logic [OB-1:0] o;

  key_wr_t     kw;
  match_req_t  req;
  logic        m_done;
  logic [4:0]  m_idx;
  logic [1:0]  lv_fin;

  hrhp_keymatch u_match (
    .clk  (clk),
    .rst  (rst),
    .kw   (kw),
    .req  (req),
    .done (m_done),
    .hidx (m_idx)
  );

  assign b        = cur.data_byte;
  assign o        = boff;
  assign sticky   = (fv != V_CONT);
  assign q_pop    = (bst == BS_IDLE) && q_valid && (!out_valid || !out_stall);
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign dval     = 4'(b - CH_ZERO);
  assign is_ws    = (b == CH_SP) || ((b >= 8'd9) && (b <= 8'd13));
  assign prod     = {1'b0, vnum, 3'b000} + {3'b000, vnum, 1'b0} + 36'(dval);

  always_comb begin
    lv_next = lv; ps_next = ps; lcc_next = lcc; fb_next = fb;
    key_len_next = key_len; cand_lo_next = cand_lo; cand_hi_next = cand_hi;
    vnum_next = vnum; vneg_next = vneg; vphase_next = vphase;
    bc_next = bc;
    v = V_CONT; kind = K_NONE; fs = '0; fe = '0;
    mark = 1'b0; redo = 1'b0; look = 1'b0;
    pos = o - fb;
    kw = '{en: 1'b0, addr: pos[KS_AW-1:0], data: b};
    if (sticky) begin
      v = fv;
    end else begin
      unique case (lv)
        LV_FIRST: begin
          unique case (ps)
            PS_METHOD: if (cur.is_sp) begin
              mark = 1'b1; kind = K_METHOD; ps_next = PS_URI;
              if (pos < OB'(2)) v = V_ERROR;
            end
            PS_URI: begin
              if (cur.is_sp) begin
                mark = 1'b1; kind = K_URI; ps_next = PS_PROT;
                if (pos == '0) v = V_ERROR;
              end else if (b == CH_QMARK) begin
                mark = 1'b1; kind = K_URI; ps_next = PS_QUERY;
              end
            end
            PS_QUERY: if (cur.is_sp) begin
              mark = 1'b1; kind = K_QUERY; ps_next = PS_PROT;
            end
            PS_PROT: if (cur.is_cr) begin
              kind = K_PROTOCOL; fs = fb; fe = o;
              lcc_next = '1;
              if (pos != OB'(pfl)) v = V_ERROR;
              ps_next = PS_LF;
            end
            PS_LF: begin
              if (cur.is_lf) ps_next = PS_FCONT;
              else v = V_ERROR;
            end
            PS_FCONT: begin
              if (cur.is_cr) begin
                ps_next = PS_FFIN;
              end else begin
                lv_next = LV_HEAD; ps_next = PS_KEY;
                lcc_next = '1; fb_next = o; redo = 1'b1;
              end
            end
            default: begin
              if (cur.is_lf) begin
                lv_next = LV_HEAD; ps_next = PS_KEY; fb_next = o + OB'(1);
              end else begin
                v = V_ERROR;
              end
            end
          endcase
        end
        LV_HEAD: begin
          unique case (ps)
            PS_KEY: begin
              if (cur.is_cr) begin
                if (lcc == '0) begin
                  lv_next = LV_END; fb_next = o + OB'(1);
                end else begin
                  v = V_ERROR;
                end
              end else begin
                if (lcc == '0) begin
                  case (b)
                    "A": begin cand_lo_next = 5'd0;  cand_hi_next = 5'd4;  end
                    "C": begin cand_lo_next = 5'd5;  cand_hi_next = 5'd9;  end
                    "I": begin cand_lo_next = 5'd10; cand_hi_next = 5'd10; end
                    "H": begin cand_lo_next = 5'd11; cand_hi_next = 5'd11; end
                    "L": begin cand_lo_next = 5'd12; cand_hi_next = 5'd13; end
                    "R": begin cand_lo_next = 5'd14; cand_hi_next = 5'd15; end
                    "U": begin cand_lo_next = 5'd16; cand_hi_next = 5'd16; end
                    default: begin
                      cand_lo_next = UNKNOWN_IDX; cand_hi_next = UNKNOWN_IDX;
                    end
                  endcase
                end
                kw.en = (pos < OB'(KEY_STORE_DEPTH));
                if (b == CH_COLON) begin
                  key_len_next = pos;
                  mark = 1'b1; kind = K_KEY; ps_next = PS_VAL;
                  if (pos == '0) v = V_ERROR;
                end
              end
            end
            PS_VAL: if (!cur.is_sp) begin
              ps_next = PS_VALRUN; fb_next = o;
              vnum_next = '0; vneg_next = 1'b0; vphase_next = 2'd0;
              redo = 1'b1;
            end
            PS_VALRUN: begin
              if (cur.is_cr) begin
                mark = 1'b1; kind = K_VALUE; ps_next = PS_HEND;
                if (pos == '0) v = V_ERROR;
                else if (cand_lo < UNKNOWN_IDX && cand_hi < UNKNOWN_IDX) look = 1'b1;
              end else if (cur.is_lf && prev != CH_CR) begin
                v = V_ERROR;
              end else if (vphase == 2'd0) begin
                if (is_ws) begin
                  vphase_next = 2'd0;
                end else if (b == CH_PLUS) begin
                  vphase_next = 2'd1;
                end else if (b == CH_MINUS) begin
                  vneg_next = 1'b1; vphase_next = 2'd1;
                end else if (is_digit) begin
                  vnum_next = 32'(dval); vphase_next = 2'd1;
                end else begin
                  vphase_next = 2'd2;
                end
              end else if (vphase == 2'd1) begin
                if (is_digit) vnum_next = (prod[35:32] != '0) ? '1 : prod[31:0];
                else vphase_next = 2'd2;
              end
            end
            default: begin
              if (cur.is_lf) begin
                ps_next = PS_KEY; lcc_next = '1; fb_next = o + OB'(1);
              end else begin
                v = V_ERROR;
              end
            end
          endcase
        end
        LV_END: begin
          if (cur.is_lf) begin
            lv_next = LV_BODY; lcc_next = '1; fb_next = o + OB'(1);
          end else begin
            v = V_ERROR;
          end
        end
        default: begin
          if (hlv == '0) begin
            v = V_COMPLETE;
          end else begin
            bc_next = bc + 32'd1;
            if (bc_next == hlv) v = V_COMPLETE;
          end
        end
      endcase
      if (mark) begin
        fs = fb; fe = o; lcc_next = '1; fb_next = o + OB'(1);
      end
      if (v == V_CONT) lcc_next = lcc_next + LCC_BITS'(1);
    end
    mlen = o + OB'(1) - fb_next;
    vf = v;
    if (!sticky && v == V_CONT && cur.chunk_end) begin
      if (lv_next == LV_FIRST && ps_next == PS_METHOD)
        vf = (mlen == '0 || mlen > OB'(mml)) ? V_ERROR : V_PENDING;
      else if (lv_next == LV_HEAD && ps_next == PS_KEY)
        vf = V_COMPLETE;
      else if (lv_next == LV_BODY)
        vf = (hlv != '0 && bc_next < hlv) ? V_PENDING : V_COMPLETE;
      else
        vf = V_PENDING;
    end
    if (bst != BS_PASS || redo) kw.en = 1'b0;
    req = '{start: (bst == BS_PASS) && look, lo: cand_lo, hi: cand_hi, len: key_len};
  end

  // verdict once the name match is back
  always_comb begin
    lv_fin = cur.chunk_end ? V_PENDING : V_CONT;
    if (m_idx == LENGTH_IDX && vneg && vnum != '0) lv_fin = V_ERROR;
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bst <= BS_IDLE; lv <= LV_FIRST; ps <= PS_METHOD; lcc <= '1;
      boff <= '0; fb <= '0; key_len <= '1;
      cand_lo <= UNKNOWN_IDX; cand_hi <= UNKNOWN_IDX;
      vnum <= '0; vneg <= 1'b0; vphase <= 2'd0; hlv <= '0; bc <= '0;
      prev <= '0; fv <= V_CONT; mml <= 5'd10; pfl <= 5'd8;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_METHOD_MAX: mml <= cfg_data;
          REG_PROTO_LEN:  pfl <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (bst)
        BS_IDLE: if (q_pop) bst <= BS_PASS;
        BS_PASS: begin
          if (!sticky) begin
            lv <= lv_next; ps <= ps_next; lcc <= lcc_next; fb <= fb_next;
            key_len <= key_len_next; cand_lo <= cand_lo_next; cand_hi <= cand_hi_next;
            vnum <= vnum_next; vneg <= vneg_next; vphase <= vphase_next; bc <= bc_next;
          end
          if (!redo) begin
            field_kind <= kind;
            field_start <= 16'(fs);
            field_stop <= 16'(fe);
            if (!sticky) begin
              boff <= o + OB'(1);
              prev <= b;
            end
            if (look) begin
              bst <= BS_LOOK;
            end else begin
              verdict <= vf;
              header_index <= UNKNOWN_IDX;
              content_len <= hlv;
              out_valid <= 1'b1;
              if (vf >= V_COMPLETE) fv <= vf;
              bst <= BS_IDLE;
            end
          end
        end
        BS_LOOK: if (m_done) begin
          if (m_idx == LENGTH_IDX && !(vneg && vnum != '0)) begin
            hlv <= vnum;
            content_len <= vnum;
          end else begin
            content_len <= hlv;
          end
          verdict <= lv_fin;
          header_index <= m_idx;
          if (lv_fin >= V_COMPLETE) fv <= lv_fin;
          out_valid <= 1'b1;
          bst <= BS_IDLE;
        end
        default: bst <= BS_IDLE;
      endcase
    end
  end

  `HRHP_ASSERT(a_final_sticky, clk, rst, (fv != V_CONT) |=> (fv != V_CONT), "final verdict cleared")
  `HRHP_ASSERT(a_match_cands, clk, rst, req.start |-> (req.lo <= req.hi && req.hi < UNKNOWN_IDX), "bad candidate range")
  `HRHP_ASSERT(a_match_len, clk, rst, req.start |-> (req.len != '0), "name match on empty key")
  `HRHP_ASSERT_NEVER(a_pop_busy, clk, rst, q_pop && out_valid && out_stall, "pop with result slot held")

endmodule

@@ sv/http_request_head_parser_core.sv @@
// Byte-serial HTTP/1.1 request head parser. Bytes enter through a two-entry
// queue, so the source can run ahead while the parser works; every accepted byte
// yields exactly one result transfer with the verdict, any field that ended on it
// and the Content-Length seen so far. Each byte is pulled from the queue into a
// register and then takes one parse step; the first byte of a header key after
// the request line and the first byte of a header value take a second step.
// When a header value ends and the key's first letter names table entries, the
// name match walks the stored key bytes against each candidate name in turn.
// Results sit in an output register, so a stalled output does not stop input
// transfers until the queue fills. Complete and error verdicts stay until reset.
module http_request_head_parser_core
  import hrhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        chunk_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  verdict,
  output logic [2:0]  field_kind,
  output logic [15:0] field_start,
  output logic [15:0] field_stop,
  output logic [4:0]  header_index,
  output logic [31:0] content_len
);

  logic  q_valid, q_pop;
  item_t q_item;

  hrhp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .chunk_end (chunk_end),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  hrhp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .verdict      (verdict),
    .field_kind   (field_kind),
    .field_start  (field_start),
    .field_stop   (field_stop),
    .header_index (header_index),
    .content_len  (content_len)
  );

endmodule

@@ verif/tb_http_request_head_parser_core.sv @@
`timescale 1ns / 100ps

module tb_http_request_head_parser_core;
  import hrhp_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  typedef enum logic [1:0] {LV_FIRST, LV_HEAD, LV_END, LV_BODY} level_t;
  typedef enum logic [3:0] {
    PS_METHOD, PS_URI, PS_QUERY, PS_PROTO, PS_LF, PS_FCONT, PS_FFIN,
    PS_KEY, PS_VAL, PS_VALRUN, PS_HEND
  } pstate_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [2:0]  kind;
    logic [15:0] fstart;
    logic [15:0] fstop;
    logic [4:0]  hidx;
    logic [31:0] clen;
  } parse_result_t;

  class head_parser_scoreboard;
    string         names[TABLE_ENTRIES];
    bit [4:0]      max_method, proto_len;
    level_t        lvl;
    pstate_t       ps;
    bit [15:0]     line_cnt, offset, fbeg, kbeg, ksep;
    bit [4:0]      cand_lo, cand_hi;
    bit [7:0]      keys[KEY_STORE_DEPTH];
    bit [63:0]     num;
    bit            neg;
    bit [1:0]      dphase, sticky;
    bit [31:0]     clen_val, body_cnt;
    bit [7:0]      prev;
    parse_result_t pending[$];
    int            errors;

    function new();
      names = '{"Accept", "Accept-Charset", "Accept-Encoding", "Accept-Language",
                "Authorization", "Cookie", "Connection", "Content-Length",
                "Content-Range", "Content-Type", "If-Modified-Since", "Host",
                "Last-Modified", "Last-Modified-Since", "Referer", "Range",
                "User-Agent"};
      max_method = 10;
      proto_len = 8;
      lvl = LV_FIRST;
      ps = PS_METHOD;
      line_cnt = '1;
      offset = 0;
      fbeg = 0;
      kbeg = 0;
      ksep = '1;
      cand_lo = UNKNOWN_IDX;
      cand_hi = UNKNOWN_IDX;
      foreach (keys[i]) keys[i] = 0;
      num = 0;
      neg = 0;
      dphase = 0;
      sticky = 0;
      clen_val = 0;
      body_cnt = 0;
      prev = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [4:0] v);
      if (idx == REG_METHOD_MAX) max_method = v;
      else proto_len = v;
    endfunction

    function void feed_digit(bit [7:0] b);
      if (dphase == 0) begin
        if (b == CH_SP || (b >= 9 && b <= 13)) return;
        if (b == CH_PLUS) dphase = 1;
        else if (b == CH_MINUS) begin
          neg = 1;
          dphase = 1;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
          num = b - CH_ZERO;
          dphase = 1;
        end else dphase = 2;
      end else if (dphase == 1) begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          num = num * 10 + (b - CH_ZERO);
          if (num > 64'hFFFF_FFFF) num = 64'hFFFF_FFFF;
        end else dphase = 2;
      end
    endfunction

    function bit [4:0] match_key();
      bit [15:0] len;
      bit        same;
      len = ksep - kbeg;
      if (cand_lo >= TABLE_ENTRIES || cand_hi >= TABLE_ENTRIES) return UNKNOWN_IDX;
      for (int i = cand_lo; i <= cand_hi; i++) begin
        if (names[i].len() != len) continue;
        same = 1;
        for (int k = 1; k < len && k < KEY_STORE_DEPTH; k++) begin
          if (keys[k] != names[i][k]) begin
            same = 0;
            break;
          end
        end
        if (same) return 5'(i);
      end
      return UNKNOWN_IDX;
    endfunction

    function void set_candidates(bit [7:0] b);
      bit [4:0] lo, hi;
      lo = UNKNOWN_IDX;
      hi = UNKNOWN_IDX;
      case (b)
        "A": begin lo = 0; hi = 4; end
        "C": begin lo = 5; hi = 9; end
        "I": begin lo = 10; hi = 10; end
        "H": begin lo = 11; hi = 11; end
        "L": begin lo = 12; hi = 13; end
        "R": begin lo = 14; hi = 15; end
        "U": begin lo = 16; hi = 16; end
        default: begin
          kbeg = '1;
          ksep = '1;
        end
      endcase
      cand_lo = lo;
      cand_hi = hi;
    endfunction

    function parse_result_t step(bit [7:0] b, bit last);
      parse_result_t r;
      bit            redo, mark;
      bit [15:0]     o, span;
      r = '0;
      r.hidx = UNKNOWN_IDX;
      o = offset;
      if (sticky != V_CONT) begin
        r.verdict = sticky;
        r.clen = clen_val;
        return r;
      end
      redo = 1;
      while (redo) begin
        mark = 0;
        redo = 0;
        span = o - fbeg;
        case (lvl)
          LV_FIRST: begin
            case (ps)
              PS_METHOD: if (b == CH_SP) begin
                mark = 1; r.kind = K_METHOD; ps = PS_URI;
                if (span < 2) r.verdict = V_ERROR;
              end
              PS_URI: if (b == CH_SP) begin
                mark = 1; r.kind = K_URI; ps = PS_PROTO;
                if (span == 0) r.verdict = V_ERROR;
              end else if (b == CH_QMARK) begin
                mark = 1; r.kind = K_URI; ps = PS_QUERY;
              end
              PS_QUERY: if (b == CH_SP) begin
                mark = 1; r.kind = K_QUERY; ps = PS_PROTO;
              end
              PS_PROTO: if (b == CH_CR) begin
                r.kind = K_PROTOCOL; r.fstart = fbeg; r.fstop = o;
                line_cnt = '1;
                if (span != proto_len) r.verdict = V_ERROR;
                ps = PS_LF;
              end
              PS_LF: if (b == CH_LF) ps = PS_FCONT; else r.verdict = V_ERROR;
              PS_FCONT: if (b == CH_CR) ps = PS_FFIN;
              else begin
                lvl = LV_HEAD; ps = PS_KEY; line_cnt = '1; fbeg = o; redo = 1;
              end
              default: if (b == CH_LF) begin
                lvl = LV_HEAD; ps = PS_KEY; fbeg = o + 16'd1;
              end else r.verdict = V_ERROR;
            endcase
          end
          LV_HEAD: begin
            if (ps == PS_KEY) begin
              if (b == CH_CR) begin
                if (line_cnt == 0) begin
                  lvl = LV_END; fbeg = o + 16'd1;
                end else r.verdict = V_ERROR;
              end else begin
                if (line_cnt == 0) set_candidates(b);
                if (span < KEY_STORE_DEPTH) keys[span] = b;
                if (b == CH_COLON) begin
                  kbeg = fbeg; ksep = o; mark = 1; r.kind = K_KEY; ps = PS_VAL;
                  if (span == 0) r.verdict = V_ERROR;
                end
              end
            end else if (ps == PS_VAL) begin
              if (b != CH_SP) begin
                ps = PS_VALRUN; fbeg = o; num = 0; neg = 0; dphase = 0; redo = 1;
              end
            end else if (ps == PS_VALRUN) begin
              if (b == CH_CR) begin
                mark = 1; r.kind = K_VALUE; ps = PS_HEND;
                if (span == 0) r.verdict = V_ERROR;
                else begin
                  r.hidx = match_key();
                  if (r.hidx == LENGTH_IDX) begin
                    if (neg && num != 0) r.verdict = V_ERROR;
                    else clen_val = num[31:0];
                  end
                end
              end else if (b == CH_LF && prev != CH_CR) r.verdict = V_ERROR;
              else feed_digit(b);
            end else begin
              if (b == CH_LF) begin
                ps = PS_KEY; line_cnt = '1; fbeg = o + 16'd1;
              end else r.verdict = V_ERROR;
            end
          end
          LV_END: begin
            if (b == CH_LF) begin
              lvl = LV_BODY; line_cnt = '1; fbeg = o + 16'd1;
            end else r.verdict = V_ERROR;
          end
          default: begin
            if (clen_val == 0) r.verdict = V_COMPLETE;
            else begin
              body_cnt++;
              if (body_cnt == clen_val) r.verdict = V_COMPLETE;
            end
          end
        endcase
        if (mark) begin
          r.fstart = fbeg; r.fstop = o; line_cnt = '1; fbeg = o + 16'd1;
        end
        if (r.verdict != V_CONT) break;
        line_cnt++;
      end
      if (r.verdict == V_CONT && last) begin
        if (lvl == LV_FIRST && ps == PS_METHOD) begin
          span = o + 16'd1 - fbeg;
          r.verdict = (span == 0 || span > max_method) ? V_ERROR : V_PENDING;
        end else if (lvl == LV_HEAD && ps == PS_KEY) r.verdict = V_COMPLETE;
        else if (lvl == LV_BODY)
          r.verdict = (clen_val > 0 && body_cnt < clen_val) ? V_PENDING : V_COMPLETE;
        else r.verdict = V_PENDING;
      end
      if (r.verdict >= V_COMPLETE) sticky = r.verdict;
      offset = o + 16'd1;
      prev = b;
      r.clen = clen_val;
      return r;
    endfunction

    function void note_byte(bit [7:0] b, bit last);
      pending.push_back(step(b, last));
    endfunction

    function void cmp_field(string nm, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $error("%s: expected %0d, actual %0d", nm, e, a);
        errors++;
      end
    endfunction

    function void check_result(parse_result_t got);
      parse_result_t e;
      if (pending.size() == 0) begin
        $error("result transfer with no byte outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp_field("verdict", e.verdict, got.verdict);
      cmp_field("field_kind", e.kind, got.kind);
      cmp_field("field_start", e.fstart, got.fstart);
      cmp_field("field_stop", e.fstop, got.fstop);
      cmp_field("header_index", e.hidx, got.hidx);
      cmp_field("content_len", e.clen, got.clen);
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_write;
  logic [0:0]  cfg_index;
  logic [4:0]  cfg_data;
  logic        in_valid, in_stall;
  logic [7:0]  data_byte;
  logic        chunk_end;
  logic        out_valid, out_stall;
  logic [1:0]  verdict;
  logic [2:0]  field_kind;
  logic [15:0] field_start, field_stop;
  logic [4:0]  header_index;
  logic [31:0] content_len;

  head_parser_scoreboard sb = new();
  head_parser_scoreboard plan = new();

  bit [7:0] byte_q[$];
  bit       last_q[$];
  int       send_idle, recv_stall, hold_left, cycles;
  int       pressure_req, pressure_ack;

  http_request_head_parser_core uut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_http_request_head_parser_core: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_byte(data_byte, chunk_end);
      if (out_valid && !out_stall)
        sb.check_result('{verdict, field_kind, field_start, field_stop,
                          header_index, content_len});
    end
  end

  // receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (pressure_ack != pressure_req) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      pressure_ack <= pressure_req;
    end else out_stall <= ($urandom_range(1, 100) <= recv_stall);
  end

  // chunk end only where it cannot end the request early
  function bit chunk_ok();
    bit [15:0] len;
    case (plan.lvl)
      LV_FIRST: begin
        if (plan.ps == PS_METHOD) begin
          len = plan.offset + 16'd1 - plan.fbeg;
          return len >= 1 && len <= plan.max_method;
        end
        return plan.ps inside {PS_URI, PS_QUERY, PS_PROTO, PS_LF};
      end
      LV_HEAD: return plan.ps inside {PS_VAL, PS_VALRUN};
      LV_BODY: return 1;
      default: return 0;
    endcase
  endfunction

  function void put(bit [7:0] b);
    bit last;
    last = chunk_ok() && $urandom_range(0, 7) == 0;
    byte_q.push_back(b);
    last_q.push_back(last);
    void'(plan.step(b, last));
  endfunction

  function void put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function void put_header(string k, string v);
    put_str(k);
    put_str(": ");
    put_str(v);
    put(CH_CR);
    put(CH_LF);
  endfunction

  function bit [7:0] key_byte();
    bit [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_COLON);
    return c;
  endfunction

  function bit [7:0] value_byte();
    bit [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_CR || c == CH_LF);
    return c;
  endfunction

  function void put_number();
    int sign, n;
    if ($urandom_range(0, 3) == 0) put(8'h09);
    sign = $urandom_range(0, 3);
    if (sign == 0) put(CH_PLUS);
    else if (sign == 1) put(CH_MINUS);
    n = $urandom_range(1, 12);
    repeat (n) put(sign == 1 ? CH_ZERO : CH_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 4) == 0) put_str("x7");
  endfunction

  function void add_random_header();
    bit [7:0] key[$];
    bit [7:0] c;
    int       sel, idx, k;
    bit       numeric;
    string    firsts;
    firsts = "ACIHLRU";
    numeric = 0;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      idx = (sel < 55) ? $urandom_range(0, TABLE_ENTRIES - 1) : LENGTH_IDX;
      for (k = 0; k < plan.names[idx].len(); k++) key.push_back(plan.names[idx][k]);
      if (sel < 55 && $urandom_range(0, 4) == 0) begin
        k = $urandom_range(1, key.size() - 1);
        key[k] = (key[k] == "x") ? "y" : "x";
      end else numeric = (idx == LENGTH_IDX);
    end else begin
      key.push_back($urandom_range(0, 1) ? firsts[$urandom_range(0, 6)] : key_byte());
      repeat ($urandom_range(0, 39)) key.push_back(key_byte());
    end
    foreach (key[i]) put(key[i]);
    put(CH_COLON);
    repeat ($urandom_range(0, 2)) put(CH_SP);
    if (numeric) put_number();
    else begin
      do c = value_byte(); while (c == CH_SP);
      put(c);
      repeat ($urandom_range(0, 23)) put(value_byte());
    end
    put(CH_CR);
    put(CH_LF);
  endfunction

  task write_cfg(logic [0:0] idx, logic [4:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.write_reg(idx, v);
    plan.write_reg(idx, v);
  endtask

  task send_stream(int idle_pct, int stall_pct);
    int i;
    bit acc;
    send_idle = idle_pct;
    recv_stall = stall_pct;
    i = 0;
    while (i < byte_q.size()) begin
      @(posedge clk);
      acc = in_valid && !in_stall;
      if (acc) i++;
      if (in_valid && !acc) continue;
      if (i < byte_q.size() && $urandom_range(1, 100) > send_idle) begin
        in_valid <= 1'b1;
        data_byte <= byte_q[i];
        chunk_end <= last_q[i];
      end else in_valid <= 1'b0;
    end
    byte_q.delete();
    last_q.delete();
  endtask

  task drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_METHOD_MAX;
    cfg_data <= '0;
    in_valid <= 1'b0;
    data_byte <= '0;
    chunk_end <= 1'b0;
    send_idle = 0;
    recv_stall = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    write_cfg(REG_METHOD_MAX, 5'($urandom_range(3, 31)));
    write_cfg(REG_PROTO_LEN, 8);
    put_str("GET /index.html?lang=en HTTP/1.1");
    put(CH_CR);
    put(CH_LF);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      put_header(plan.names[i], i == LENGTH_IDX ? "-0" : "v");
    put_header("Content-Length", "99999999999");
    put_header("Content-Length", "\t+12x5");
    send_stream(0, 0);
    drain();

    write_cfg(REG_METHOD_MAX, 1);
    write_cfg(REG_PROTO_LEN, 31);
    while (byte_q.size() < 250) add_random_header();
    pressure_req++;
    send_stream(0, 0);
    drain();

    write_cfg(REG_METHOD_MAX, 31);
    write_cfg(REG_PROTO_LEN, 1);
    while (byte_q.size() < 250) add_random_header();
    send_stream(65, 0);
    drain();

    write_cfg(REG_METHOD_MAX, 5'($urandom_range(1, 31)));
    write_cfg(REG_PROTO_LEN, 5'($urandom_range(1, 31)));
    while (byte_q.size() < 250) add_random_header();
    send_stream(0, 65);
    drain();

    while (byte_q.size() < 220) add_random_header();
    put_header("Content-Length", "37");
    put(CH_CR);
    put(CH_LF);
    repeat (37) put(8'($urandom_range(0, 255)));
    repeat (8) put(8'($urandom_range(0, 255)));
    send_stream(16, 16);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("tb_http_request_head_parser_core: PASS");
    else $display("tb_http_request_head_parser_core: FAIL");
    $finish;
  end

endmodule
